// ----- rtl/mtbi_pkg.sv -----
// ----------------------------------------------------------------------------
// mtbi_pkg
// Types, register indexes and scoring helpers shared by the best-interval
// trimmer.
// ----------------------------------------------------------------------------
package mtbi_pkg;

   localparam int POS_W   = 16;
   localparam int SCORE_W = 24;
   localparam int CFG_W   = 8;
   localparam int PROD_W  = POS_W + CFG_W;
   localparam int SUM_W   = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;

   localparam logic [POS_W-1:0]   POS_MAX   = '1;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   typedef enum logic [1:0] {
      CSR_MATCH_SCORE       = 2'd0,
      CSR_MISMATCH_PENALTY  = 2'd1,
      CSR_END_BONUS         = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] read_start;
      logic [POS_W-1:0] read_end;
      logic             left_is_full;
      logic             right_is_full;
      logic [POS_W-1:0] mismatch_pos;
      logic             first_mismatch;
      logic             last_mismatch;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]   best_start;
      logic [POS_W-1:0]   best_end;
      logic [SCORE_W-1:0] peak_score;
      logic               was_trimmed;
      logic               left_full_out;
      logic               right_full_out;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] match_score;
      logic [CFG_W-1:0] mismatch_penalty;
      logic [CFG_W-1:0] end_bonus;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]   cur_start;
      logic [POS_W-1:0]   cur_end;
      logic [SCORE_W-1:0] cur_score;
      logic [POS_W-1:0]   best_start;
      logic [POS_W-1:0]   best_end;
      logic [SCORE_W-1:0] peak_score;
      logic [POS_W-1:0]   saved_start;
      logic               saved_left_full;
   } state_type;

   // Saturating add of a score and a match-run product.
   function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                  input logic [PROD_W-1:0]  b);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(a) + SUM_W'(b);
      return (sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
   endfunction

   // Offset just after a position, held at the top of the range.
   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
      return (p == POS_MAX) ? p : p + POS_W'(1);
   endfunction

   // Length of the match run from end e up to p; zero when p is behind.
   function automatic logic [POS_W-1:0] run_len(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] e);
      return (p > e) ? p - e : '0;
   endfunction

   // Candidate beats the best: higher score, or equal nonzero and longer.
   function automatic logic is_better(input logic [POS_W-1:0]   c_start,
                                      input logic [POS_W-1:0]   c_end,
                                      input logic [SCORE_W-1:0] c_score,
                                      input logic [POS_W-1:0]   b_start,
                                      input logic [POS_W-1:0]   b_end,
                                      input logic [SCORE_W-1:0] b_score);
      logic [POS_W-1:0] c_len;
      logic [POS_W-1:0] b_len;
      c_len = c_end - c_start;
      b_len = b_end - b_start;
      return (c_score > b_score) ||
             ((c_score != '0) && (c_score == b_score) && (c_len > b_len));
   endfunction

endpackage

// ----- rtl/mtbi_step.sv -----
// ----------------------------------------------------------------------------
// mtbi_step
// Next-state and result logic for one mismatch item of the trimmer.
// ----------------------------------------------------------------------------
module mtbi_step (
   input  mtbi_pkg::state_type state,
   input  mtbi_pkg::cfg_type   cfg,
   input  mtbi_pkg::req_type   item,
   output mtbi_pkg::state_type state_next,
   output mtbi_pkg::rsp_type   result
);
   import mtbi_pkg::*;

   logic [POS_W-1:0]   a_start;
   logic [POS_W-1:0]   a_end;
   logic [SCORE_W-1:0] a_score;
   logic [POS_W-1:0]   len1;
   logic [POS_W-1:0]   e1;
   logic [PROD_W-1:0]  prod1;
   logic [SCORE_W-1:0] s1;
   logic [POS_W-1:0]   b1_start;
   logic [POS_W-1:0]   b1_end;
   logic [SCORE_W-1:0] b1_score;
   logic               absorb;
   logic [POS_W-1:0]   inc_e1;
   logic [POS_W-1:0]   inc_p;
   logic [POS_W-1:0]   st2;
   logic [POS_W-1:0]   e2;
   logic [SCORE_W-1:0] s2;
   logic [PROD_W-1:0]  prod_abs;
   logic [PROD_W-1:0]  prod_rst;
   logic [POS_W-1:0]   e3;
   logic [SCORE_W-1:0] s3_run;
   logic [SCORE_W-1:0] s3;
   logic [POS_W-1:0]   b2_start;
   logic [POS_W-1:0]   b2_end;
   logic [SCORE_W-1:0] b2_score;
   logic [POS_W-1:0]   saved_start;
   logic               saved_left;

   // Open a new interval on the first mismatch, else continue.
   assign saved_start = item.first_mismatch ? item.read_start : state.saved_start;
   assign saved_left  = item.first_mismatch ? item.left_is_full : state.saved_left_full;
   assign a_start     = item.first_mismatch ? item.read_start : state.cur_start;
   assign a_end       = item.first_mismatch ? item.read_start : state.cur_end;
   assign a_score     = item.first_mismatch ?
                        (item.left_is_full ? SCORE_W'(cfg.end_bonus) : '0) :
                        state.cur_score;

   // Match run up to the mismatch.
   assign len1  = run_len(item.mismatch_pos, a_end);
   assign e1    = (item.mismatch_pos > a_end) ? item.mismatch_pos : a_end;
   assign prod1 = PROD_W'(len1) * PROD_W'(cfg.match_score);
   assign s1    = sat_add(a_score, prod1);

   always_comb begin
      if (item.first_mismatch ||
          is_better(a_start, e1, s1, state.best_start, state.best_end, state.peak_score)) begin
         b1_start = a_start;
         b1_end   = e1;
         b1_score = s1;
      end else begin
         b1_start = state.best_start;
         b1_end   = state.best_end;
         b1_score = state.peak_score;
      end
   end

   // Absorb the mismatch or restart after it.
   assign absorb = (s1 >= SCORE_W'(cfg.mismatch_penalty));
   assign inc_e1 = sat_inc(e1);
   assign inc_p  = sat_inc(item.mismatch_pos);
   assign st2    = absorb ? a_start : inc_p;
   assign e2     = absorb ? inc_e1 : inc_p;
   assign s2     = absorb ? s1 - SCORE_W'(cfg.mismatch_penalty) : '0;

   // Closing run to read_end; both candidate lengths go in parallel.
   assign prod_abs = PROD_W'(run_len(item.read_end, inc_e1)) * PROD_W'(cfg.match_score);
   assign prod_rst = PROD_W'(run_len(item.read_end, inc_p)) * PROD_W'(cfg.match_score);
   assign e3       = (item.read_end > e2) ? item.read_end : e2;
   assign s3_run   = sat_add(s2, absorb ? prod_abs : prod_rst);
   assign s3       = item.right_is_full ?
                     sat_add(s3_run, PROD_W'(cfg.end_bonus)) : s3_run;

   always_comb begin
      if (is_better(st2, e3, s3, b1_start, b1_end, b1_score)) begin
         b2_start = st2;
         b2_end   = e3;
         b2_score = s3;
      end else begin
         b2_start = b1_start;
         b2_end   = b1_end;
         b2_score = b1_score;
      end
   end

   always_comb begin
      state_next.saved_start     = saved_start;
      state_next.saved_left_full = saved_left;
      state_next.cur_start       = st2;
      if (item.last_mismatch) begin
         state_next.cur_end    = e3;
         state_next.cur_score  = s3;
         state_next.best_start = b2_start;
         state_next.best_end   = b2_end;
         state_next.peak_score = b2_score;
      end else begin
         state_next.cur_end    = e2;
         state_next.cur_score  = s2;
         state_next.best_start = b1_start;
         state_next.best_end   = b1_end;
         state_next.peak_score = b1_score;
      end
   end

   always_comb begin
      result.best_start     = b2_start;
      result.best_end       = b2_end;
      result.peak_score     = b2_score;
      result.was_trimmed    = 1'b1;
      result.left_full_out  = saved_left;
      result.right_full_out = item.right_is_full;
      if ((b2_start == saved_start) && (b2_end == item.read_end)) begin
         result.was_trimmed = 1'b0;
      end else if (b2_end == b2_start) begin
         result.peak_score     = '0;
         result.left_full_out  = 1'b0;
         result.right_full_out = 1'b0;
      end else begin
         if (b2_start > saved_start) begin
            result.left_full_out = 1'b0;
         end
         if (b2_end < item.read_end) begin
            result.right_full_out = 1'b0;
         end
      end
   end

endmodule

// ----- rtl/mismatch_trim_best_interval.sv -----
// ----------------------------------------------------------------------------
// mismatch_trim_best_interval
// Trims a gapless read alignment to its best-scoring sub-interval.
// ----------------------------------------------------------------------------
// Send the mismatch offsets of an alignment in ascending order, one item each,
// with first_mismatch on the opening item and last_mismatch on the closing
// one; only the closing item returns a result (best interval, score, trimmed
// flag and updated full flags). The block takes one item per clock unless a
// closing item is held: an item is first held in the input register, then the
// scoring logic updates the running and best interval and loads the result
// register, where the result of a closing item is then valid. The per-item
// state update is combinational (match-run multiply, saturating add, compare
// and select), which sets the one-item-per-cycle rate.
// Items that close no alignment keep flowing while a result waits on
// rsp_ready; a closing item holds in the input register until the result
// register frees. Write the scoring registers only while the block is idle.
module mismatch_trim_best_interval (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mtbi_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mtbi_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [mtbi_pkg::CFG_W-1:0] csr_wdata
);
   import mtbi_pkg::*;

   // Input register
   logic      in_valid_ff;
   req_type   in_item_ff;
   // Scoring state and configuration
   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   // Result register
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   step_result;
   // Handshake control
   logic      rsp_free;
   logic      advance;

   // The result slot frees when it is empty or being taken this cycle.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   // Advance the held item unless it closes an alignment and the slot is busy.
   assign advance   = in_valid_ff && (!in_item_ff.last_mismatch || rsp_free);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mtbi_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // Input register: load on accept, drop once the item advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   // Running and best interval advance with each item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: fill on a closing item, clear when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.last_mismatch) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_item_ff.last_mismatch) begin
         rsp_data_ff <= step_result;
      end
   end

   // Scoring registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_score      <= CFG_W'(1);
         cfg_ff.mismatch_penalty <= CFG_W'(4);
         cfg_ff.end_bonus        <= CFG_W'(5);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MATCH_SCORE:      cfg_ff.match_score      <= csr_wdata;
            CSR_MISMATCH_PENALTY: cfg_ff.mismatch_penalty <= csr_wdata;
            CSR_END_BONUS:        cfg_ff.end_bonus        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // An interval never ends before it starts.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.cur_end >= state_ff.cur_start) && (state_ff.best_end >= state_ff.best_start))
      else $error("interval end below its start");

   // An empty best interval reports score 0 and both full flags clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.best_end == rsp_data_ff.best_start) &&
      rsp_data_ff.was_trimmed |->
      (rsp_data_ff.peak_score == '0) && !rsp_data_ff.left_full_out &&
      !rsp_data_ff.right_full_out)
      else $error("empty interval with nonzero score or flags");

   // An item that closes no alignment never raises a result.
   assert property (@(posedge clock) disable iff (reset)
      advance && !in_item_ff.last_mismatch |=> !$rose(rsp_valid_ff))
      else $error("result from a non-closing item");

   // A closing item never overwrites a result that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(advance && in_item_ff.last_mismatch))
      else $error("pending result overwritten");
`endif

endmodule

// ----- bench/mismatch_trim_best_interval_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mismatch_trim_best_interval_tb
// Self-checking bench for the best-interval trimmer. Plain tasks drive
// alignments as streams of mismatch items and write the scoring registers
// between phases; the result side is stalled at random. A scoreboard class
// keeps its own copy of the running and best interval, predicts each closing
// result and checks every returned result field by field, in order.
// ----------------------------------------------------------------------------
module mismatch_trim_best_interval_tb;
   import mtbi_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned IDLE_PCT = 19;
   localparam logic [1:0]  CSR_UNUSED_INDEX = 2'd3;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the running interval (run_*) and the best one so far
   // (top_*), queues the result each closing item should produce.
   // -------------------------------------------------------------------------
   class best_interval_board;
      logic [CFG_W-1:0]   match_score;
      logic [CFG_W-1:0]   mismatch_penalty;
      logic [CFG_W-1:0]   end_bonus;
      logic [POS_W-1:0]   run_start;
      logic [POS_W-1:0]   run_end;
      logic [SCORE_W-1:0] run_score;
      logic [POS_W-1:0]   top_start;
      logic [POS_W-1:0]   top_end;
      logic [SCORE_W-1:0] top_score;
      logic [POS_W-1:0]   open_start;
      logic               open_left_full;
      rsp_type            trim_results_q[$];
      int unsigned        errors;
      int unsigned        checked;
      int unsigned        kept_whole;
      int unsigned        trimmed;
      int unsigned        emptied;

      function new();
         match_score       = 8'd1;
         mismatch_penalty  = 8'd4;
         end_bonus         = 8'd5;
         run_start         = '0;
         run_end           = '0;
         run_score         = '0;
         top_start         = '0;
         top_end           = '0;
         top_score         = '0;
         open_start        = '0;
         open_left_full    = 1'b0;
         errors            = 0;
         checked           = 0;
         kept_whole        = 0;
         trimmed           = 0;
         emptied           = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_MATCH_SCORE:      match_score = value;
            CSR_MISMATCH_PENALTY: mismatch_penalty = value;
            CSR_END_BONUS:        end_bonus = value;
            default: ;
         endcase
      endfunction

      function logic [SCORE_W-1:0] add_sat(logic [SCORE_W-1:0] a, longint unsigned b);
         longint unsigned total;
         total = a + b;
         return (total > SCORE_MAX) ? SCORE_MAX : total[SCORE_W-1:0];
      endfunction

      function logic [POS_W-1:0] step_past(logic [POS_W-1:0] p);
         return (p == POS_MAX) ? p : p + POS_W'(1);
      endfunction

      // Matches from the running end up to p; nothing when p lies behind.
      function void extend_to(logic [POS_W-1:0] p);
         longint unsigned bases;
         bases = 0;
         if (p > run_end) begin
            bases   = p - run_end;
            run_end = p;
         end
         run_score = add_sat(run_score, bases * match_score);
      endfunction

      function void promote();
         logic [POS_W-1:0] run_len;
         logic [POS_W-1:0] top_len;
         run_len = run_end - run_start;
         top_len = top_end - top_start;
         if (run_score > top_score ||
             (run_score != '0 && run_score == top_score && run_len > top_len)) begin
            top_start = run_start;
            top_end   = run_end;
            top_score = run_score;
         end
      endfunction

      function void note_mismatch(req_type item);
         rsp_type want;
         if (item.first_mismatch) begin
            open_start     = item.read_start;
            open_left_full = item.left_is_full;
            run_start      = item.read_start;
            run_end        = item.read_start;
            run_score      = item.left_is_full ? SCORE_W'(end_bonus) : '0;
            extend_to(item.mismatch_pos);
            top_start = run_start;
            top_end   = run_end;
            top_score = run_score;
         end else begin
            extend_to(item.mismatch_pos);
            promote();
         end
         // absorb the mismatch if the score pays for it, else restart past it
         if (run_score >= SCORE_W'(mismatch_penalty)) begin
            run_end   = step_past(run_end);
            run_score = run_score - SCORE_W'(mismatch_penalty);
         end else begin
            run_start = step_past(item.mismatch_pos);
            run_end   = run_start;
            run_score = '0;
         end
         if (!item.last_mismatch) return;
         extend_to(item.read_end);
         if (item.right_is_full) run_score = add_sat(run_score, end_bonus);
         promote();
         want.best_start     = top_start;
         want.best_end       = top_end;
         want.peak_score     = top_score;
         want.was_trimmed    = 1'b1;
         want.left_full_out  = open_left_full;
         want.right_full_out = item.right_is_full;
         if (top_start == open_start && top_end == item.read_end) begin
            want.was_trimmed = 1'b0;
            kept_whole++;
         end else if (top_end == top_start) begin
            want.peak_score     = '0;
            want.left_full_out  = 1'b0;
            want.right_full_out = 1'b0;
            emptied++;
         end else begin
            if (top_start > open_start) want.left_full_out = 1'b0;
            if (top_end < item.read_end) want.right_full_out = 1'b0;
            trimmed++;
         end
         trim_results_q = {trim_results_q, want};
      endfunction

      function void flag(string what, longint unsigned want, longint unsigned got);
         errors++;
         if (errors <= 10)
            $display("%0t mismatch %0d: %s expected %0h got %0h", $time, errors, what,
                     want, got);
      endfunction

      function void check_trim(rsp_type got);
         rsp_type want;
         if (trim_results_q.size() == 0) begin
            flag("result with none pending, payload", 0, got);
            return;
         end
         want = trim_results_q.pop_front();
         checked++;
         if (got.best_start !== want.best_start)
            flag("best_start", want.best_start, got.best_start);
         if (got.best_end !== want.best_end)
            flag("best_end", want.best_end, got.best_end);
         if (got.peak_score !== want.peak_score)
            flag("peak_score", want.peak_score, got.peak_score);
         if (got.was_trimmed !== want.was_trimmed)
            flag("was_trimmed", want.was_trimmed, got.was_trimmed);
         if (got.left_full_out !== want.left_full_out)
            flag("left_full_out", want.left_full_out, got.left_full_out);
         if (got.right_full_out !== want.right_full_out)
            flag("right_full_out", want.right_full_out, got.right_full_out);
      endfunction

      function int unsigned pending();
         return trim_results_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [CFG_W-1:0] csr_wdata;

   best_interval_board board = new();

   int unsigned req_idle_pct = IDLE_PCT;
   int unsigned rsp_idle_pct = IDLE_PCT;
   int unsigned holds_requested = 0;
   int unsigned cycles = 0;
   int unsigned items_sent = 0;
   int unsigned settings_written = 0;

   mismatch_trim_best_interval i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: fail and end the run once the cycle counter passes its limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  board.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Monitor: sample handshakes with the values held before the edge. Results
   // always belong to older items, so the order of the calls does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_trim(rsp_data);
         if (req_valid && req_ready) board.note_mismatch(req_data);
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_wdata);
      end
   end

   // Result side: random back-pressure, plus long hold-offs on request. The
   // hold is counted here so the sender keeps offering items meanwhile.
   initial begin : rsp_side
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic req_type mismatch_item(input int unsigned rs, input int unsigned re,
                                             input bit lf, input bit rf,
                                             input int unsigned pos,
                                             input bit first, input bit last);
      req_type item;
      item.read_start     = POS_W'(rs);
      item.read_end       = POS_W'(re);
      item.left_is_full   = lf;
      item.right_is_full  = rf;
      item.mismatch_pos   = POS_W'(pos);
      item.first_mismatch = first;
      item.last_mismatch  = last;
      return item;
   endfunction

   // Offer one item, idling first at random; return at the accepting edge
   // with valid still high so a following item can go out back to back.
   task automatic push_item(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid, wait for every pending result, then let the pipe empty of
   // items that close nothing.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] match, input logic [CFG_W-1:0] penalty,
                            input logic [CFG_W-1:0] bonus, input bit poke_unused);
      write_reg(CSR_MATCH_SCORE, match);
      write_reg(CSR_MISMATCH_PENALTY, penalty);
      write_reg(CSR_END_BONUS, bonus);
      // an index past the register list must leave all settings alone
      if (poke_unused) write_reg(CSR_UNUSED_INDEX, CFG_W'($urandom));
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   // Mostly small values so that scores and penalties compete; extremes too.
   function automatic logic [CFG_W-1:0] pick_setting(input int unsigned small_hi);
      int unsigned roll;
      roll = $urandom_range(7);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return CFG_W'($urandom_range(small_hi));
   endfunction

   // One alignment: usually well formed with random spacing, sometimes pure
   // noise, a missing opening or closing mark, or offsets that step back.
   task automatic send_random_alignment();
      req_type          item;
      int unsigned      roll;
      int unsigned      count;
      int unsigned      span;
      int unsigned      reach;
      int unsigned      pos;
      int unsigned      k;
      logic [POS_W-1:0] rs;
      logic [POS_W-1:0] re;
      logic             lf;
      logic             rf;
      roll = $urandom_range(99);
      if (roll < 12) begin
         item.read_start     = POS_W'($urandom);
         item.read_end       = POS_W'($urandom);
         item.left_is_full   = 1'($urandom_range(1));
         item.right_is_full  = 1'($urandom_range(1));
         item.mismatch_pos   = POS_W'($urandom);
         item.first_mismatch = 1'($urandom_range(1));
         item.last_mismatch  = 1'($urandom_range(1));
         push_item(item);
         return;
      end
      count = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      span  = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(count, 90);
      rs    = ($urandom_range(3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(2000));
      re    = (rs + span > POS_MAX) ? POS_MAX : POS_W'(rs + span);
      lf    = 1'($urandom_range(1));
      rf    = 1'($urandom_range(1));
      reach = span / count;
      if (reach == 0) reach = 1;
      pos = rs + $urandom_range(reach - 1);
      for (k = 0; k < count; k++) begin
         item = mismatch_item(rs, re, lf, rf, (pos > POS_MAX) ? POS_MAX : pos,
                              k == 0, k == count - 1);
         if (roll < 17 && k == 0) item.first_mismatch = 1'b0;
         else if (roll >= 17 && roll < 22 && k == count - 1) item.last_mismatch = 1'b0;
         push_item(item);
         pos = pos + $urandom_range(1, 2 * reach);
         if (roll >= 22 && roll < 27 && $urandom_range(1) == 1)
            pos = (pos > 3 * reach) ? pos - 3 * reach : 0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase;
      int unsigned n;
      int unsigned rs;
      int unsigned target;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MATCH_SCORE;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings. Open with an item that carries no first
      // mark, so it continues from the cleared state.
      push_item(mismatch_item(7, 9, 1, 1, 3, 0, 1));
      push_item(mismatch_item(100, 140, 1, 1, 120, 1, 1));
      // mismatch right at the read start, then close to the end
      push_item(mismatch_item(200, 230, 0, 0, 200, 1, 0));
      push_item(mismatch_item(200, 230, 0, 0, 201, 0, 0));
      push_item(mismatch_item(200, 230, 0, 0, 229, 0, 1));
      // mismatch below the read start on the opening item
      push_item(mismatch_item(300, 320, 1, 0, 250, 1, 1));
      // offsets and read end behind the running end
      push_item(mismatch_item(400, 415, 0, 1, 410, 1, 0));
      push_item(mismatch_item(400, 415, 0, 1, 405, 0, 0));
      push_item(mismatch_item(400, 415, 0, 1, 420, 0, 1));
      // offset at the top of the range, absorbed and restarted
      push_item(mismatch_item(65500, 65535, 1, 1, 65535, 1, 1));
      push_item(mismatch_item(65535, 65535, 0, 0, 65535, 1, 1));
      // whole range of the read
      push_item(mismatch_item(0, 65535, 1, 1, 0, 1, 0));
      push_item(mismatch_item(0, 65535, 1, 1, 65535, 0, 1));
      // no first mark: carry on from the previous alignment
      push_item(mismatch_item(50, 60, 1, 0, 55, 0, 1));
      settle();

      // Equal score on a longer later interval takes over the best one.
      configure(8'd1, 8'd10, 8'd3, 1'b0);
      push_item(mismatch_item(0, 14, 1, 0, 5, 1, 0));
      push_item(mismatch_item(0, 14, 1, 0, 14, 0, 1));
      settle();

      // All scoring off: every score stays zero, so the first run of each alignment stays the best one.
      configure(8'd0, 8'd0, 8'd0, 1'b0);
      push_item(mismatch_item(500, 520, 0, 0, 500, 1, 1));
      push_item(mismatch_item(600, 640, 1, 1, 610, 1, 0));
      push_item(mismatch_item(600, 640, 1, 1, 630, 0, 1));
      settle();

      // Every register at its top value; poke the unused index as well.
      configure(8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_item(mismatch_item(1000, 1100, 1, 1, 1050, 1, 0));
      push_item(mismatch_item(1000, 1100, 1, 1, 1051, 0, 0));
      push_item(mismatch_item(1000, 1100, 1, 1, 1099, 0, 1));
      settle();

      // Drive the score into saturation: one nearly full-range match run,
      // then a chain of closing items that each add the right-end bonus.
      configure(8'hFF, 8'h00, 8'hFF, 1'b0);
      push_item(mismatch_item(0, 65535, 1, 1, 65534, 1, 0));
      for (n = 0; n < 262; n++)
         push_item(mismatch_item($urandom_range(65535), 65535, 1'($urandom_range(1)), 1,
                                 65535, 0, 1));
      settle();

      // Random phases, each under its own settings; one runs with no idling.
      for (phase = 0; phase < 5; phase++) begin
         configure(pick_setting(4), pick_setting(12), pick_setting(20), phase == 0);
         req_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
         rsp_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
         target = items_sent + 32;
         while (items_sent < target) send_random_alignment();
         settle();
      end
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;

      // Hold off the result side while short closing alignments keep coming,
      // so the block fills up and stalls its input; then pause until drained.
      configure(8'd2, 8'd5, 8'd7, 1'b0);
      holds_requested++;
      for (n = 0; n < 36; n++) begin
         rs = $urandom_range(60000);
         push_item(mismatch_item(rs, rs + $urandom_range(40), 1'($urandom_range(1)),
                                 1'($urandom_range(1)), rs + $urandom_range(40), 1, 1));
      end
      settle();

      $display("closed %0d alignments: %0d kept whole, %0d trimmed, %0d emptied",
               board.kept_whole + board.trimmed + board.emptied, board.kept_whole,
               board.trimmed, board.emptied);
      $display("sent %0d items under %0d register settings, checked %0d results, %0d errors",
               items_sent, settings_written, board.checked, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
